### rtl/core/vector_l2_normalizer_unit_defines.svh
// Assertion macros shared by the vector normalizer RTL
`ifndef VECTOR_L2_NORMALIZER_UNIT_DEFINES_SVH
`define VECTOR_L2_NORMALIZER_UNIT_DEFINES_SVH

// Assert an implication on every clock edge outside reset
`define VLN_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Assert an implication whose consequent holds in the cycle after the antecedent
`define VLN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/vln_pkg.sv
// Shared types and constants for the vector normalizer
`timescale 1ns / 1ps
package vln_pkg;
    localparam int unsigned COMP_W = 16;
    localparam int unsigned SUM_W = 37;
    localparam int unsigned ROOT_W = 19;
    localparam int unsigned LEN_W = 7;
    localparam int unsigned DIV_STEPS = 32;
    localparam int unsigned SQRT_STEPS = 19;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_FETCH,
        ST_DIVIDE,
        ST_EMIT
    } state_t;
endpackage

### rtl/core/vln_sqrt.sv
// Bit-pair iterative integer square root, one result bit for each pair of radicand bits
`timescale 1ns / 1ps
module vln_sqrt
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [vln_pkg::SUM_W-1:0]     radicand,
    output logic                          busy,
    output logic                          done,
    output logic [vln_pkg::ROOT_W-1:0]    root
);
    localparam int unsigned CNT_W = $clog2(vln_pkg::SQRT_STEPS + 1);

    logic [vln_pkg::SUM_W:0]      rem_reg, rem_next;
    logic [vln_pkg::SUM_W:0]      rad_reg, rad_next;
    logic [vln_pkg::ROOT_W-1:0]   root_reg, root_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [vln_pkg::SUM_W+1:0]    trial;
    logic [vln_pkg::SUM_W+1:0]    shifted;

    // Shift two radicand bits into the remainder and try subtracting 4*root+1
    always_comb
    begin
        shifted = {rem_reg[vln_pkg::SUM_W-1:0], rad_reg[vln_pkg::SUM_W:vln_pkg::SUM_W-1]};
        trial = shifted - {{(vln_pkg::SUM_W+2-vln_pkg::ROOT_W-2){1'b0}}, root_reg, 2'b01};
        rem_next = rem_reg;
        rad_next = rad_reg;
        root_next = root_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start && !busy_reg)
        begin
            rem_next = '0;
            rad_next = {1'b0, radicand};
            root_next = '0;
            cnt_next = CNT_W'(vln_pkg::SQRT_STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[vln_pkg::SUM_W-2:0], 2'b00};
            if (!trial[vln_pkg::SUM_W+1])
            begin
                rem_next = trial[vln_pkg::SUM_W:0];
                root_next = {root_reg[vln_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[vln_pkg::SUM_W:0];
                root_next = {root_reg[vln_pkg::ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        rad_reg <= rad_next;
        root_reg <= root_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign root = root_reg;
endmodule

### rtl/core/vln_div.sv
// Restoring divider for magnitude*32768 / norm, one quotient bit per cycle
`timescale 1ns / 1ps
module vln_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [vln_pkg::COMP_W:0]      magnitude,
    input  logic [vln_pkg::ROOT_W-1:0]    divisor,
    output logic                          busy,
    output logic                          done,
    output logic [vln_pkg::DIV_STEPS-1:0] quotient
);
    localparam int unsigned CNT_W = $clog2(vln_pkg::DIV_STEPS + 1);

    logic [vln_pkg::DIV_STEPS-1:0] quo_reg, quo_next;
    logic [vln_pkg::ROOT_W:0]      rem_reg, rem_next;
    logic [vln_pkg::ROOT_W-1:0]    dvs_reg, dvs_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [vln_pkg::ROOT_W:0]      shifted;
    logic [vln_pkg::ROOT_W+1:0]    diff;

    always_comb
    begin
        shifted = {rem_reg[vln_pkg::ROOT_W-1:0], quo_reg[vln_pkg::DIV_STEPS-1]};
        diff = {1'b0, shifted} - {2'b00, dvs_reg};
        quo_next = quo_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start && !busy_reg)
        begin
            quo_next = {{(vln_pkg::DIV_STEPS-vln_pkg::COMP_W-16){1'b0}}, magnitude, 15'd0};
            rem_next = '0;
            dvs_next = divisor;
            cnt_next = CNT_W'(vln_pkg::DIV_STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[vln_pkg::ROOT_W+1])
            begin
                rem_next = diff[vln_pkg::ROOT_W:0];
                quo_next = {quo_reg[vln_pkg::DIV_STEPS-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[vln_pkg::DIV_STEPS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quotient = quo_reg;
endmodule

### rtl/core/vector_l2_normalizer_unit.sv
// Top level: L2 vector normalizer with shared square root and divider
// Accumulate: each component is transferred in IDLE, then square-added in SQUARE before the next is taken.
// Completion: square root, then per component fetch, divider load, divide, done and emit.
// Results appear one per strobe cycle and cannot be stalled by the receiver.
// Reset clears control state, loads vector_length to 64 and the square sum to one.
`timescale 1ns / 1ps
`include "vector_l2_normalizer_unit_defines.svh"
module vector_l2_normalizer_unit
#(
    parameter int unsigned MAX_DIMS = 64
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [vln_pkg::COMP_W-1:0]    component,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [vln_pkg::LEN_W-1:0]            cfg_data,
    output logic                                 strobe,
    output logic signed [vln_pkg::COMP_W-1:0]    normalized,
    output logic                                 last_of_vector
);
    localparam int unsigned IDX_W = $clog2(MAX_DIMS);
    localparam int unsigned CNT_W = $clog2(MAX_DIMS + 1);

    logic [vln_pkg::COMP_W-1:0]     mem [MAX_DIMS];
    logic [vln_pkg::COMP_W-1:0]     rd_reg;

    vln_pkg::state_t                state_reg, state_next;
    logic [vln_pkg::LEN_W-1:0]      len_reg;
    logic [CNT_W-1:0]               fill_reg, fill_next;
    logic [CNT_W-1:0]               idx_reg, idx_next;
    logic [vln_pkg::SUM_W-1:0]      sum_reg, sum_next;
    logic [vln_pkg::COMP_W-1:0]     in_reg;
    logic [vln_pkg::ROOT_W-1:0]     norm_reg, norm_next;
    logic signed [vln_pkg::COMP_W-1:0] out_reg, out_next;
    logic                           last_reg, last_next;
    logic                           stb_reg, stb_next;

    logic [CNT_W-1:0]               eff_len;
    logic                           accept;
    logic                           wr_en;
    logic [IDX_W-1:0]               wr_addr;
    logic [vln_pkg::COMP_W-1:0]     in_mag;
    logic [2*vln_pkg::COMP_W-1:0]   square;
    logic [CNT_W-1:0]               fill_inc;

    logic                           sq_start, sq_busy, sq_done;
    logic                           dv_start, dv_busy, dv_done;
    logic [vln_pkg::ROOT_W-1:0]     root;
    logic [vln_pkg::COMP_W:0]       rd_mag;
    logic [vln_pkg::DIV_STEPS-1:0]  quo;

    assign accept = start && (state_reg == vln_pkg::ST_IDLE);
    assign busy = (state_reg != vln_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        priority if (len_reg == '0)
            eff_len = CNT_W'(1);
        else if ({{(32-vln_pkg::LEN_W){1'b0}}, len_reg} > MAX_DIMS)
            eff_len = CNT_W'(MAX_DIMS);
        else
            eff_len = CNT_W'(len_reg);
    end

    assign wr_en = accept;
    assign wr_addr = (fill_reg >= CNT_W'(MAX_DIMS)) ? IDX_W'(MAX_DIMS - 1) : fill_reg[IDX_W-1:0];
    assign fill_inc = {1'b0, wr_addr} + 1'b1;
    assign in_mag = in_reg[vln_pkg::COMP_W-1] ? (~in_reg + 1'b1) : in_reg;
    assign square = in_mag * in_mag;
    assign rd_mag = rd_reg[vln_pkg::COMP_W-1] ? ({1'b0, ~rd_reg} + 1'b1) : {1'b0, rd_reg};

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= component;
        rd_reg <= mem[idx_reg[IDX_W-1:0]];
        in_reg <= accept ? component : in_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        fill_next = fill_reg;
        idx_next = idx_reg;
        sum_next = sum_reg;
        norm_next = norm_reg;
        out_next = out_reg;
        last_next = last_reg;
        stb_next = 1'b0;
        sq_start = 1'b0;
        dv_start = 1'b0;
        unique case (state_reg)
            vln_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    fill_next = fill_inc;
                    state_next = vln_pkg::ST_SQUARE;
                end
            end
            vln_pkg::ST_SQUARE:
            begin
                sum_next = sum_reg + {{(vln_pkg::SUM_W-2*vln_pkg::COMP_W){1'b0}}, square};
                if (fill_reg >= eff_len)
                begin
                    sq_start = 1'b1;
                    state_next = vln_pkg::ST_ROOT;
                end
                else
                    state_next = vln_pkg::ST_IDLE;
            end
            vln_pkg::ST_ROOT:
            begin
                if (sq_done)
                begin
                    norm_next = (root == '0) ? vln_pkg::ROOT_W'(1) : root;
                    idx_next = '0;
                    state_next = vln_pkg::ST_FETCH;
                end
            end
            vln_pkg::ST_FETCH:
            begin
                dv_start = 1'b0;
                state_next = vln_pkg::ST_DIVIDE;
            end
            vln_pkg::ST_DIVIDE:
            begin
                if (!dv_busy && !dv_done)
                    dv_start = 1'b1;
                if (dv_done)
                begin
                    if (rd_reg[vln_pkg::COMP_W-1])
                        out_next = (quo >= 32'd32768) ? 16'sh8000
                                   : vln_pkg::COMP_W'(~quo + 1'b1);
                    else
                        out_next = (quo > 32'd32767) ? 16'sh7FFF : vln_pkg::COMP_W'(quo);
                    last_next = (idx_reg + 1'b1 == fill_reg);
                    stb_next = 1'b1;
                    state_next = vln_pkg::ST_EMIT;
                end
            end
            vln_pkg::ST_EMIT:
            begin
                if (last_reg)
                begin
                    fill_next = '0;
                    sum_next = vln_pkg::SUM_W'(1);
                    state_next = vln_pkg::ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    state_next = vln_pkg::ST_FETCH;
                end
            end
            default: state_next = vln_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vln_pkg::ST_IDLE;
            len_reg <= vln_pkg::LEN_W'(64);
            fill_reg <= '0;
            idx_reg <= '0;
            sum_reg <= vln_pkg::SUM_W'(1);
            stb_reg <= 1'b0;
            last_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                len_reg <= cfg_data;
            fill_reg <= fill_next;
            idx_reg <= idx_next;
            sum_reg <= sum_next;
            stb_reg <= stb_next;
            last_reg <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        norm_reg <= norm_next;
        out_reg <= out_next;
    end

    vln_sqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sum_next),
        .busy     (sq_busy),
        .done     (sq_done),
        .root     (root)
    );

    vln_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (dv_start),
        .magnitude (rd_mag),
        .divisor   (norm_reg),
        .busy      (dv_busy),
        .done      (dv_done),
        .quotient  (quo)
    );

    assign strobe = stb_reg;
    assign normalized = out_reg;
    assign last_of_vector = last_reg;

    `VLN_ASSERT_IMPL(a_strobe_in_emit, strobe, state_reg == vln_pkg::ST_EMIT, "strobe outside emit")
    `VLN_ASSERT_IMPL(a_units_exclusive, sq_busy, !dv_busy, "root and divider both busy")
    `VLN_ASSERT_NEXT(a_last_clears, strobe && last_of_vector, fill_reg == '0, "fill not cleared")
    `VLN_ASSERT_IMPL(a_fill_bound, 1'b1, fill_reg <= CNT_W'(MAX_DIMS), "fill count overflow")
endmodule

### verif/testbench.sv
// Self-checking testbench for the L2 vector normalizer unit
`timescale 1ns / 1ps
module testbench;
    typedef struct {
        logic signed [vln_pkg::COMP_W-1:0] normalized;
        logic                              last_of_vector;
    } norm_result_t;

    class norm_scoreboard;
        logic [vln_pkg::COMP_W-1:0]  stored[64];
        logic [vln_pkg::SUM_W-1:0]   square_sum;
        int unsigned                 fill_count;
        logic [vln_pkg::LEN_W-1:0]   vector_length;
        norm_result_t                pending[$];
        int unsigned                 errors;

        function void clear();
            square_sum = 1;
            fill_count = 0;
            vector_length = 64;
            pending.delete();
            errors = 0;
        endfunction

        function void set_length(logic [vln_pkg::LEN_W-1:0] len);
            vector_length = len;
        endfunction

        function logic [63:0] floor_root(logic [63:0] v);
            logic [63:0] root;
            logic [63:0] lo;
            logic [63:0] hi;
            lo = 0;
            hi = 64'd1 << 19;
            while (hi - lo > 1)
            begin
                root = (lo + hi) >> 1;
                if (root * root <= v)
                    lo = root;
                else
                    hi = root;
            end
            return lo;
        endfunction

        function logic signed [vln_pkg::COMP_W-1:0] scale(logic [vln_pkg::COMP_W-1:0] raw,
                                                          logic [63:0] norm);
            logic [63:0] mag;
            logic [63:0] q;
            mag = raw[15] ? 64'(17'h10000 - raw) : 64'(raw);
            q = (mag << 15) / norm;
            if (raw[15])
                return (q >= 32768) ? 16'sh8000 : 16'(-q);
            return (q > 32767) ? 16'sh7fff : 16'(q);
        endfunction

        function void note_component(logic signed [vln_pkg::COMP_W-1:0] comp);
            int unsigned len;
            logic [63:0] mag;
            logic [63:0] norm;
            norm_result_t r;
            len = vector_length;
            if (len == 0) len = 1;
            if (len > 64) len = 64;
            if (fill_count >= 64) fill_count = 63;
            stored[fill_count] = comp;
            fill_count++;
            mag = comp < 0 ? 64'(-32'(comp)) : 64'(comp);
            square_sum = square_sum + vln_pkg::SUM_W'(mag * mag);
            if (fill_count < len) return;
            norm = floor_root(64'(square_sum));
            if (norm == 0) norm = 1;
            for (int unsigned i = 0; i < fill_count; i++)
            begin
                r.normalized = scale(stored[i], norm);
                r.last_of_vector = (i + 1 == fill_count);
                pending.push_back(r);
            end
            fill_count = 0;
            square_sum = 1;
        endfunction

        function void check_result(logic signed [vln_pkg::COMP_W-1:0] n, logic l);
            norm_result_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result normalized=%0d last=%0b", n, l);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (n !== e.normalized)
            begin
                $error("normalized expected %0d actual %0d", e.normalized, n);
                errors++;
            end
            if (l !== e.last_of_vector)
            begin
                $error("last_of_vector expected %0b actual %0b", e.last_of_vector, l);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [vln_pkg::COMP_W-1:0] component;
    logic cfg_valid;
    logic cfg_ready;
    logic [vln_pkg::LEN_W-1:0] cfg_data;
    logic strobe;
    logic signed [vln_pkg::COMP_W-1:0] normalized;
    logic last_of_vector;

    norm_scoreboard board;

    vector_l2_normalizer_unit u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .component(component),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .strobe(strobe), .normalized(normalized), .last_of_vector(last_of_vector)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && strobe)
            board.check_result(normalized, last_of_vector);
    end

    task automatic send_component(logic signed [vln_pkg::COMP_W-1:0] value, bit gaps);
        int unsigned wait_cycles;
        wait_cycles = gaps ? $urandom_range(0, 10) : 0;
        if (wait_cycles != 0)
        begin
            start <= 1'b0;
            repeat (wait_cycles) @(posedge clk);
        end
        start <= 1'b1;
        component <= value;
        @(posedge clk);
        while (busy) @(posedge clk);
        board.note_component(value);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_length(logic [vln_pkg::LEN_W-1:0] len);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= len;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        board.set_length(len);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [vln_pkg::COMP_W-1:0] random_component();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'(int'($urandom_range(0, 8)) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        int unsigned sent;
        board = new();
        board.clear();
        rst_n = 0;
        start = 0;
        component = 0;
        cfg_valid = 0;
        cfg_data = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset length of 64, extremes and a zero vector
        for (int i = 0; i < 64; i++)
            send_component(i[0] ? 16'sh7fff : 16'sh8000, 0);
        write_length(1);
        send_component(16'sh7fff, 1);
        send_component(16'sh8000, 1);
        send_component(0, 1);
        send_component(-1, 1);
        write_length(0);
        send_component(5, 1);
        write_length(3);
        send_component(0, 1);
        send_component(0, 1);
        send_component(0, 1);
        send_component(16'sh1234, 1);
        send_component(16'shedcb, 1);
        send_component(16'sh5555, 1);
        write_length(127);
        send_component(16'shaaaa, 1);
        send_component(3, 1);
        // shorten mid-vector below the current count
        write_length(1);
        send_component(-7, 1);

        sent = 0;
        while (sent < 232)
        begin
            if ($urandom_range(0, 5) == 0)
                write_length($urandom_range(0, 4) == 0 ? 7'($urandom) : 7'($urandom_range(1, 8)));
            send_component(random_component(), $urandom_range(0, 3) != 0);
            sent++;
        end
        drain();
        if (board.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule
